FILE: design/cslex_pkg.sv
// Shared types, constants and character classes for the C subset lexer.
`default_nettype none
package cslex_pkg;

  localparam int MAX_NAME_LENGTH = 256;
  localparam int NAME_LEN_W = $clog2(MAX_NAME_LENGTH);
  localparam int KW_NUM = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [62:0] LIMIT63 = '1;

  localparam logic [2:0] REG_KW_A = 3'd0;
  localparam logic [2:0] REG_KW_B = 3'd1;
  localparam logic [2:0] REG_KW_C = 3'd2;
  localparam logic [2:0] REG_KW_D = 3'd3;
  localparam logic [2:0] REG_KW_COUNT = 3'd4;

  localparam logic [3:0] KIND_IDENT = 4'd0;
  localparam logic [3:0] KIND_KEYWORD = 4'd1;
  localparam logic [3:0] KIND_INTEGER = 4'd2;
  localparam logic [3:0] KIND_OPERATOR = 4'd3;
  localparam logic [3:0] KIND_LBRACE = 4'd4;
  localparam logic [3:0] KIND_RBRACE = 4'd5;
  localparam logic [3:0] KIND_LPAREN = 4'd6;
  localparam logic [3:0] KIND_RPAREN = 4'd7;
  localparam logic [3:0] KIND_SEMI = 4'd8;
  localparam logic [3:0] KIND_ASSIGN = 4'd9;
  localparam logic [3:0] KIND_NAME_CHAR = 4'd10;
  localparam logic [3:0] KIND_END = 4'd11;
  localparam logic [3:0] KIND_ERROR = 4'd12;

  localparam logic [3:0] OP_MINUS = 4'd0;
  localparam logic [3:0] OP_PLUS = 4'd1;
  localparam logic [3:0] OP_SLASH = 4'd2;
  localparam logic [3:0] OP_STAR = 4'd3;
  localparam logic [3:0] OP_NOT = 4'd4;
  localparam logic [3:0] OP_TILDE = 4'd5;
  localparam logic [3:0] OP_LT = 4'd6;
  localparam logic [3:0] OP_GT = 4'd7;
  localparam logic [3:0] OP_AND = 4'd8;
  localparam logic [3:0] OP_OR = 4'd9;
  localparam logic [3:0] OP_NE = 4'd10;
  localparam logic [3:0] OP_EQ = 4'd11;
  localparam logic [3:0] OP_LE = 4'd12;
  localparam logic [3:0] OP_GE = 4'd13;

  localparam logic [3:0] ERR_LONE_AMP_BAR = 4'd0;
  localparam logic [3:0] ERR_OVERLONG = 4'd1;
  localparam logic [3:0] ERR_UNEXPECTED = 4'd2;
  localparam logic [3:0] ERR_OVERFLOW = 4'd3;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [4:0] {
    MODE_IDLE     = 5'b00001,
    MODE_NAME     = 5'b00010,
    MODE_NUMBER   = 5'b00100,
    MODE_OPERATOR = 5'b01000,
    MODE_STOPPED  = 5'b10000
  } mode_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [3:0]  detail;
    logic [15:0] line;
    logic [15:0] column;
    logic [62:0] literal_value;
    logic [7:0]  name_char;
    logic [7:0]  name_position;
  } result_t;

  typedef struct packed {
    result_t first;
    result_t second;
    logic    two;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // Returns a valid bit above the operator code.
  function automatic logic [4:0] single_op(input logic [7:0] c);
    logic [4:0] r;
    case (c)
      "-":     r = {1'b1, OP_MINUS};
      "+":     r = {1'b1, OP_PLUS};
      "/":     r = {1'b1, OP_SLASH};
      "*":     r = {1'b1, OP_STAR};
      "!":     r = {1'b1, OP_NOT};
      "~":     r = {1'b1, OP_TILDE};
      "<":     r = {1'b1, OP_LT};
      ">":     r = {1'b1, OP_GT};
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] double_op(input logic [7:0] a, input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (a == "&" && b == "&") begin
      r = {1'b1, OP_AND};
    end else if (a == "|" && b == "|") begin
      r = {1'b1, OP_OR};
    end else if (b == "=") begin
      case (a)
        "!":     r = {1'b1, OP_NE};
        "=":     r = {1'b1, OP_EQ};
        "<":     r = {1'b1, OP_LE};
        ">":     r = {1'b1, OP_GE};
        default: r = 5'd0;
      endcase
    end
    return r;
  endfunction

  // Returns a valid bit above the token kind of a one-byte symbol.
  function automatic logic [4:0] symbol_kind(input logic [7:0] c);
    logic [4:0] r;
    case (c)
      "{":     r = {1'b1, KIND_LBRACE};
      "}":     r = {1'b1, KIND_RBRACE};
      "(":     r = {1'b1, KIND_LPAREN};
      ")":     r = {1'b1, KIND_RPAREN};
      ";":     r = {1'b1, KIND_SEMI};
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic result_t make_result(input logic [3:0] kind, input logic [3:0] detail,
                                          input logic [15:0] ln, input logic [15:0] col,
                                          input logic [62:0] value, input logic [7:0] ch,
                                          input logic [7:0] pos);
    result_t r;
    r.token_kind = kind;
    r.detail = detail;
    r.line = ln;
    r.column = col;
    r.literal_value = value;
    r.name_char = ch;
    r.name_position = pos;
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: design/cslex_if.sv
// Channel interfaces for source bytes, tokens and configuration writes.
`default_nettype none
interface cslex_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

interface cslex_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [3:0]  detail;
  logic [15:0] line;
  logic [15:0] column;
  logic [62:0] literal_value;
  logic [7:0]  name_char;
  logic [7:0]  name_position;
  logic        last;
  modport source (output valid, output token_kind, output detail, output line,
                  output column, output literal_value, output name_char,
                  output name_position, output last, input ready);
  modport sink (input valid, input token_kind, input detail, input line,
                input column, input literal_value, input name_char,
                input name_position, input last, output ready);
endinterface

interface cslex_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: design/cslex_front.sv
// Front end: accepts source bytes, runs the lexer state and forms result entries.
`default_nettype none
module cslex_front (
  input  wire logic              clk,
  input  wire logic              rst,
  cslex_in_if.sink               in_ch,
  cslex_cfg_if.sink              cfg_ch,
  input  wire logic              q_full,
  output logic                   push,
  output cslex_pkg::entry_t      push_entry
);
  import cslex_pkg::*;

  logic [63:0] kw_word [KW_NUM];
  logic [2:0]  kw_count;

  mode_t                 mode, mode_next;
  logic [15:0]           line_cnt, line_cnt_next;
  logic [15:0]           col_cnt, col_cnt_next;
  logic [15:0]           start_line, start_line_next;
  logic [15:0]           start_col, start_col_next;
  logic [63:0]           name_prefix, name_prefix_next;
  logic [NAME_LEN_W-1:0] name_len, name_len_next;
  logic [62:0]           acc, acc_next;
  logic                  frozen, frozen_next;
  logic                  ovf, ovf_next;
  logic [7:0]            pend_op, pend_op_next;

  logic [7:0]  c;
  logic        accept;
  logic        first_vld, fresh_vld, do_fresh;
  result_t     first_res, fresh_res;
  logic [15:0] col_adv;
  logic [66:0] prod;
  logic [4:0]  sop, dop, sym;
  logic        kw_hit;
  logic [1:0]  kw_idx;
  logic        overlong;

  assign c = in_ch.char_code;
  assign in_ch.ready = !q_full;
  assign accept = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign col_adv = (col_cnt == 16'hFFFF) ? col_cnt : col_cnt + 16'd1;
  assign prod = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + 67'(c - "0");
  assign sop = single_op(pend_op);
  assign dop = double_op(pend_op, c);
  assign sym = symbol_kind(c);
  assign overlong = 32'(name_len) >= 32'(MAX_NAME_LENGTH - 1);

  always_comb begin
    kw_hit = 1'b0;
    kw_idx = 2'd0;
    for (int i = KW_NUM - 1; i >= 0; i--) begin
      if (32'(i) < 32'(kw_count) && 32'(name_len) <= 32'd8 && name_prefix == kw_word[i]) begin
        kw_hit = 1'b1;
        kw_idx = 2'(i);
      end
    end
  end

  always_comb begin
    mode_next = mode;
    line_cnt_next = line_cnt;
    col_cnt_next = col_cnt;
    start_line_next = start_line;
    start_col_next = start_col;
    name_prefix_next = name_prefix;
    name_len_next = name_len;
    acc_next = acc;
    frozen_next = frozen;
    ovf_next = ovf;
    pend_op_next = pend_op;
    first_vld = 1'b0;
    first_res = '0;
    fresh_vld = 1'b0;
    fresh_res = '0;
    do_fresh = 1'b0;

    case (mode)
      MODE_IDLE: begin
        do_fresh = 1'b1;
      end
      MODE_NAME: begin
        if (is_letter(c) || is_digit(c)) begin
          first_vld = 1'b1;
          if (overlong) begin
            first_res = make_result(KIND_ERROR, ERR_OVERLONG, start_line, start_col,
                                    '0, '0, '0);
            mode_next = MODE_STOPPED;
          end else begin
            first_res = make_result(KIND_NAME_CHAR, '0, start_line, start_col, '0, c,
                                    8'(name_len));
            if (32'(name_len) < 32'd8) begin
              name_prefix_next = name_prefix | (64'(c) << {name_len[2:0], 3'b000});
            end
            name_len_next = name_len + 1'b1;
            col_cnt_next = col_adv;
          end
        end else begin
          first_vld = 1'b1;
          first_res = make_result(kw_hit ? KIND_KEYWORD : KIND_IDENT,
                                  kw_hit ? {2'b00, kw_idx} : 4'd0,
                                  start_line, start_col, '0, '0, '0);
          do_fresh = 1'b1;
        end
      end
      MODE_NUMBER: begin
        if (is_letter(c) || is_digit(c)) begin
          if (overlong) begin
            first_vld = 1'b1;
            first_res = make_result(KIND_ERROR, ERR_OVERLONG, start_line, start_col,
                                    '0, '0, '0);
            mode_next = MODE_STOPPED;
          end else begin
            if (!frozen) begin
              if (is_digit(c)) begin
                if (ovf || prod > 67'(LIMIT63)) begin
                  ovf_next = 1'b1;
                end else begin
                  acc_next = prod[62:0];
                end
              end else begin
                frozen_next = 1'b1;
              end
            end
            name_len_next = name_len + 1'b1;
            col_cnt_next = col_adv;
          end
        end else if (ovf) begin
          first_vld = 1'b1;
          first_res = make_result(KIND_ERROR, ERR_OVERFLOW, start_line, start_col,
                                  '0, '0, '0);
          mode_next = MODE_STOPPED;
          do_fresh = (c == CH_NUL);
        end else begin
          first_vld = 1'b1;
          first_res = make_result(KIND_INTEGER, '0, start_line, start_col, acc, '0, '0);
          do_fresh = 1'b1;
        end
      end
      MODE_OPERATOR: begin
        first_vld = 1'b1;
        if (dop[4]) begin
          first_res = make_result(KIND_OPERATOR, dop[3:0], start_line, start_col,
                                  '0, '0, '0);
          mode_next = MODE_IDLE;
          col_cnt_next = col_adv;
        end else if (sop[4]) begin
          first_res = make_result(KIND_OPERATOR, sop[3:0], start_line, start_col,
                                  '0, '0, '0);
          do_fresh = 1'b1;
        end else if (pend_op == "=") begin
          first_res = make_result(KIND_ASSIGN, '0, start_line, start_col, '0, '0, '0);
          do_fresh = 1'b1;
        end else begin
          first_res = make_result(KIND_ERROR, ERR_LONE_AMP_BAR, start_line, start_col,
                                  '0, '0, '0);
          mode_next = MODE_STOPPED;
          do_fresh = (c == CH_NUL);
        end
      end
      MODE_STOPPED: begin
        do_fresh = (c == CH_NUL);
      end
      default: begin
        do_fresh = 1'b0;
      end
    endcase

    // The byte is handled as a fresh byte at the current position.
    if (do_fresh) begin
      mode_next = MODE_IDLE;
      if (is_letter(c)) begin
        start_line_next = line_cnt;
        start_col_next = col_cnt;
        name_prefix_next = 64'(c);
        name_len_next = NAME_LEN_W'(1);
        fresh_vld = 1'b1;
        fresh_res = make_result(KIND_NAME_CHAR, '0, line_cnt, col_cnt, '0, c, '0);
        mode_next = MODE_NAME;
        col_cnt_next = col_adv;
      end else if (is_digit(c)) begin
        start_line_next = line_cnt;
        start_col_next = col_cnt;
        acc_next = 63'(c - "0");
        name_len_next = NAME_LEN_W'(1);
        frozen_next = 1'b0;
        ovf_next = 1'b0;
        mode_next = MODE_NUMBER;
        col_cnt_next = col_adv;
      end else if (sym[4]) begin
        fresh_vld = 1'b1;
        fresh_res = make_result(sym[3:0], '0, line_cnt, col_cnt, '0, '0, '0);
        col_cnt_next = col_adv;
      end else if (sop[4] == 1'b0 && single_op(c) == 5'd0 && c != "&" && c != "|"
                   && c != "=") begin
        if (c == CH_NL) begin
          line_cnt_next = (line_cnt == 16'hFFFF) ? line_cnt : line_cnt + 16'd1;
          col_cnt_next = 16'd1;
        end else if (c == CH_SPACE) begin
          col_cnt_next = col_adv;
        end else if (c == CH_NUL) begin
          fresh_vld = 1'b1;
          fresh_res = make_result(KIND_END, '0, line_cnt, col_cnt, '0, '0, '0);
          line_cnt_next = 16'd1;
          col_cnt_next = 16'd1;
          start_line_next = 16'd1;
          start_col_next = 16'd1;
          name_prefix_next = '0;
          name_len_next = '0;
          acc_next = '0;
          frozen_next = 1'b0;
          ovf_next = 1'b0;
          pend_op_next = '0;
        end else begin
          fresh_vld = 1'b1;
          fresh_res = make_result(KIND_ERROR, ERR_UNEXPECTED, line_cnt, col_cnt,
                                  '0, '0, '0);
          mode_next = MODE_STOPPED;
        end
      end else if (single_op(c) != 5'd0 || c == "&" || c == "|" || c == "=") begin
        pend_op_next = c;
        start_line_next = line_cnt;
        start_col_next = col_cnt;
        mode_next = MODE_OPERATOR;
        col_cnt_next = col_adv;
      end else if (c == CH_NL) begin
        line_cnt_next = (line_cnt == 16'hFFFF) ? line_cnt : line_cnt + 16'd1;
        col_cnt_next = 16'd1;
      end else if (c == CH_SPACE) begin
        col_cnt_next = col_adv;
      end else if (c == CH_NUL) begin
        fresh_vld = 1'b1;
        fresh_res = make_result(KIND_END, '0, line_cnt, col_cnt, '0, '0, '0);
        line_cnt_next = 16'd1;
        col_cnt_next = 16'd1;
        start_line_next = 16'd1;
        start_col_next = 16'd1;
        name_prefix_next = '0;
        name_len_next = '0;
        acc_next = '0;
        frozen_next = 1'b0;
        ovf_next = 1'b0;
        pend_op_next = '0;
      end else begin
        fresh_vld = 1'b1;
        fresh_res = make_result(KIND_ERROR, ERR_UNEXPECTED, line_cnt, col_cnt,
                                '0, '0, '0);
        mode_next = MODE_STOPPED;
      end
    end
  end

  always_comb begin
    push = accept && (first_vld || fresh_vld);
    push_entry.first = first_vld ? first_res : fresh_res;
    push_entry.second = fresh_res;
    push_entry.two = first_vld && fresh_vld;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
      line_cnt <= 16'd1;
      col_cnt <= 16'd1;
      start_line <= 16'd1;
      start_col <= 16'd1;
      name_prefix <= '0;
      name_len <= '0;
      acc <= '0;
      frozen <= 1'b0;
      ovf <= 1'b0;
      pend_op <= '0;
    end else if (accept) begin
      mode <= mode_next;
      line_cnt <= line_cnt_next;
      col_cnt <= col_cnt_next;
      start_line <= start_line_next;
      start_col <= start_col_next;
      name_prefix <= name_prefix_next;
      name_len <= name_len_next;
      acc <= acc_next;
      frozen <= frozen_next;
      ovf <= ovf_next;
      pend_op <= pend_op_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KW_NUM; i++) begin
        kw_word[i] <= '0;
      end
      kw_count <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_KW_A:     kw_word[0] <= cfg_ch.data;
        REG_KW_B:     kw_word[1] <= cfg_ch.data;
        REG_KW_C:     kw_word[2] <= cfg_ch.data;
        REG_KW_D:     kw_word[3] <= cfg_ch.data;
        REG_KW_COUNT: kw_count <= cfg_ch.data[2:0];
        default:      kw_count <= kw_count;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: design/cslex_queue.sv
// Short entry queue between the lexer front end and the token output stage.
`default_nettype none
module cslex_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire cslex_pkg::entry_t  push_entry,
  input  wire logic               pop,
  output cslex_pkg::entry_t       head,
  output cslex_pkg::q_status_t    stat
);
  import cslex_pkg::*;

  entry_t            store [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign stat.full = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign do_push = push && !stat.full;
  assign do_pop = pop && !stat.empty;
  assign head = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/cslex_back.sv
// Back end: splits queued entries into single tokens behind an output register.
`default_nettype none
module cslex_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire cslex_pkg::entry_t    head,
  input  wire cslex_pkg::q_status_t stat,
  output logic                      pop,
  cslex_out_if.source               out_ch
);
  import cslex_pkg::*;

  logic    out_vld;
  result_t out_res;
  logic    out_last;
  logic    hold_vld;
  result_t hold;
  logic    load;

  assign load = !out_vld || out_ch.ready;
  assign pop = load && !hold_vld && !stat.empty;

  assign out_ch.valid = out_vld;
  assign out_ch.token_kind = out_res.token_kind;
  assign out_ch.detail = out_res.detail;
  assign out_ch.line = out_res.line;
  assign out_ch.column = out_res.column;
  assign out_ch.literal_value = out_res.literal_value;
  assign out_ch.name_char = out_res.name_char;
  assign out_ch.name_position = out_res.name_position;
  assign out_ch.last = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
      hold_vld <= 1'b0;
    end else if (load) begin
      if (hold_vld) begin
        out_vld <= 1'b1;
        hold_vld <= 1'b0;
      end else if (!stat.empty) begin
        out_vld <= 1'b1;
        hold_vld <= head.two;
      end else begin
        out_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (hold_vld) begin
        out_res <= hold;
        out_last <= 1'b1;
      end else begin
        out_res <= head.first;
        out_last <= !head.two;
        hold <= head.second;
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/c_subset_lexer_core.sv
// Top level of the streaming C subset lexer: front end, entry queue and token output stage.
// The block takes one source byte per cycle on char_in while the queue has room, and
// returns tokens on token_out, one token per cycle while token_out is ready. A byte gives
// zero, one or two tokens; the front end classifies it in the cycle it is accepted and
// writes its tokens as one entry into a four-entry queue, and the output stage sends an
// entry's tokens in order, the last marked by last. The output stage, at one token per
// cycle, sets the sustained rate: a stream where every byte gives two tokens is held back
// once the queue has filled. A token reaches token_out through the queue and the output
// register. Keyword words and the keyword count are written on cfg, which is always ready;
// the user must write them only while the block is idle, as the block does not enforce it.
`default_nettype none
module c_subset_lexer_core (
  input  wire logic   clk,
  input  wire logic   rst,
  cslex_in_if.sink    char_in,
  cslex_cfg_if.sink   cfg,
  cslex_out_if.source token_out
);
  import cslex_pkg::*;

  logic      q_push;
  entry_t    q_push_entry;
  logic      q_pop;
  entry_t    q_head;
  q_status_t q_stat;

  cslex_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (char_in),
    .cfg_ch     (cfg),
    .q_full     (q_stat.full),
    .push       (q_push),
    .push_entry (q_push_entry)
  );

  cslex_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_push_entry),
    .pop        (q_pop),
    .head       (q_head),
    .stat       (q_stat)
  );

  cslex_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (q_head),
    .stat   (q_stat),
    .pop    (q_pop),
    .out_ch (token_out)
  );

`ifndef ASSERT_OFF
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    token_out.valid && token_out.token_kind == KIND_END |-> token_out.last)
    else $error("End token not marked as the last token of its item.");

  a_queue_status: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("Queue reports full and empty at once.");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full)
    else $error("Front end pushed an entry into a full queue.");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !token_out.valid)
    else $error("Token output valid right after reset.");
`endif

endmodule
`default_nettype wire

FILE: test/c_subset_lexer_core_tb.sv
// Self-checking testbench for the C subset lexer core, with its own token predictor.
`timescale 1ns / 1ps
module c_subset_lexer_core_tb;
  import cslex_pkg::*;

  typedef struct packed {
    result_t tok;
    logic    last;
  } token_exp_t;

  logic clk = 1'b0;
  logic rst;

  cslex_in_if  char_in ();
  cslex_cfg_if cfg ();
  cslex_out_if token_out ();

  c_subset_lexer_core dut (
    .clk       (clk),
    .rst       (rst),
    .char_in   (char_in),
    .cfg       (cfg),
    .token_out (token_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state.
  mode_t       lx_mode;
  logic [15:0] cur_line, cur_col, tok_line, tok_col;
  logic [63:0] name_bytes;
  int unsigned name_len;
  logic [63:0] num_acc;
  logic        num_frozen, num_ovf;
  logic [7:0]  op_byte;
  logic [63:0] kw_word [4];
  logic [2:0]  kw_count;
  string       kw_text [4];

  result_t    step_toks [$];
  token_exp_t token_q [$];
  token_exp_t head_tok;

  int fail_count = 0;
  int tokens_checked = 0;
  int live_bytes = 0;
  int streams = 0;
  int cfg_writes = 0;
  int hold_ticket = 0;
  int hold_served = 0;
  bit send_gaps = 1'b1;
  bit sink_bursts = 1'b1;

  string op_list [17] = '{"-", "+", "/", "*", "!", "~", "<", ">", "&&", "||", "!=", "==",
                          "<=", ">=", "=", "&", "|"};

  function automatic bit is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit is_num(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic int op_single(input logic [7:0] c);
    case (c)
      "-": return OP_MINUS;
      "+": return OP_PLUS;
      "/": return OP_SLASH;
      "*": return OP_STAR;
      "!": return OP_NOT;
      "~": return OP_TILDE;
      "<": return OP_LT;
      ">": return OP_GT;
      default: return -1;
    endcase
  endfunction

  function automatic int op_pair(input logic [7:0] a, input logic [7:0] b);
    if (a == "&" && b == "&") return OP_AND;
    if (a == "|" && b == "|") return OP_OR;
    if (b != "=") return -1;
    case (a)
      "!": return OP_NE;
      "=": return OP_EQ;
      "<": return OP_LE;
      ">": return OP_GE;
      default: return -1;
    endcase
  endfunction

  function automatic void emit(input logic [3:0] kind, input logic [3:0] det,
                               input logic [15:0] ln, input logic [15:0] col,
                               input logic [62:0] val, input logic [7:0] ch,
                               input logic [7:0] pos);
    result_t t;
    t.token_kind = kind;
    t.detail = det;
    t.line = ln;
    t.column = col;
    t.literal_value = val;
    t.name_char = ch;
    t.name_position = pos;
    step_toks.push_back(t);
  endfunction

  function automatic void bump_col();
    if (cur_col != 16'hFFFF) cur_col++;
  endfunction

  function automatic void lex_restart();
    cur_line = 16'd1;
    cur_col = 16'd1;
    tok_line = 16'd1;
    tok_col = 16'd1;
    lx_mode = MODE_IDLE;
    name_bytes = '0;
    name_len = 0;
    num_acc = '0;
    num_frozen = 1'b0;
    num_ovf = 1'b0;
    op_byte = '0;
  endfunction

  function automatic void lex_halted(input logic [7:0] c);
    if (c == CH_NUL) begin
      emit(KIND_END, 4'd0, cur_line, cur_col, '0, '0, '0);
      lex_restart();
    end
  endfunction

  function automatic void lex_fail(input logic [3:0] code, input logic [15:0] ln,
                                   input logic [15:0] col);
    emit(KIND_ERROR, code, ln, col, '0, '0, '0);
    lx_mode = MODE_STOPPED;
  endfunction

  function automatic void lex_fresh(input logic [7:0] c);
    logic [3:0] sym_kind;
    bit is_sym;
    is_sym = 1'b1;
    sym_kind = KIND_LBRACE;
    case (c)
      "{": sym_kind = KIND_LBRACE;
      "}": sym_kind = KIND_RBRACE;
      "(": sym_kind = KIND_LPAREN;
      ")": sym_kind = KIND_RPAREN;
      ";": sym_kind = KIND_SEMI;
      default: is_sym = 1'b0;
    endcase
    if (is_alpha(c)) begin
      tok_line = cur_line;
      tok_col = cur_col;
      name_bytes = 64'(c);
      name_len = 1;
      emit(KIND_NAME_CHAR, 4'd0, tok_line, tok_col, '0, c, '0);
      lx_mode = MODE_NAME;
      bump_col();
    end else if (is_num(c)) begin
      tok_line = cur_line;
      tok_col = cur_col;
      num_acc = 64'(c - "0");
      name_len = 1;
      num_frozen = 1'b0;
      num_ovf = 1'b0;
      lx_mode = MODE_NUMBER;
      bump_col();
    end else if (is_sym) begin
      emit(sym_kind, 4'd0, cur_line, cur_col, '0, '0, '0);
      bump_col();
    end else if (op_single(c) >= 0 || c == "&" || c == "|" || c == "=") begin
      op_byte = c;
      tok_line = cur_line;
      tok_col = cur_col;
      lx_mode = MODE_OPERATOR;
      bump_col();
    end else if (c == CH_NL) begin
      if (cur_line != 16'hFFFF) cur_line++;
      cur_col = 16'd1;
    end else if (c == CH_SPACE) begin
      bump_col();
    end else if (c == CH_NUL) begin
      emit(KIND_END, 4'd0, cur_line, cur_col, '0, '0, '0);
      lex_restart();
    end else begin
      lex_fail(ERR_UNEXPECTED, cur_line, cur_col);
    end
  endfunction

  function automatic void close_name();
    int kc;
    kc = (kw_count > 3'd4) ? 4 : int'(kw_count);
    for (int i = 0; i < kc; i++) begin
      if (name_len <= 8 && name_bytes == kw_word[i]) begin
        emit(KIND_KEYWORD, 4'(i), tok_line, tok_col, '0, '0, '0);
        return;
      end
    end
    emit(KIND_IDENT, 4'd0, tok_line, tok_col, '0, '0, '0);
  endfunction

  function automatic void lex_in_name(input logic [7:0] c);
    if (is_alpha(c) || is_num(c)) begin
      if (name_len >= MAX_NAME_LENGTH - 1) begin
        lex_fail(ERR_OVERLONG, tok_line, tok_col);
        return;
      end
      emit(KIND_NAME_CHAR, 4'd0, tok_line, tok_col, '0, c, 8'(name_len));
      if (name_len < 8) name_bytes |= 64'(c) << (8 * name_len);
      name_len++;
      bump_col();
    end else begin
      close_name();
      lx_mode = MODE_IDLE;
      lex_fresh(c);
    end
  endfunction

  function automatic void lex_in_number(input logic [7:0] c);
    logic [63:0] d;
    if (is_alpha(c) || is_num(c)) begin
      if (name_len >= MAX_NAME_LENGTH - 1) begin
        lex_fail(ERR_OVERLONG, tok_line, tok_col);
        return;
      end
      if (!num_frozen) begin
        if (is_num(c)) begin
          d = 64'(c - "0");
          if (num_ovf || num_acc > ({1'b0, LIMIT63} - d) / 10) num_ovf = 1'b1;
          else num_acc = num_acc * 10 + d;
        end else begin
          num_frozen = 1'b1;
        end
      end
      name_len++;
      bump_col();
    end else if (num_ovf) begin
      lex_fail(ERR_OVERFLOW, tok_line, tok_col);
      lex_halted(c);
    end else begin
      emit(KIND_INTEGER, 4'd0, tok_line, tok_col, num_acc[62:0], '0, '0);
      lx_mode = MODE_IDLE;
      lex_fresh(c);
    end
  endfunction

  function automatic void lex_in_operator(input logic [7:0] c);
    int code;
    code = op_pair(op_byte, c);
    if (code >= 0) begin
      emit(KIND_OPERATOR, 4'(code), tok_line, tok_col, '0, '0, '0);
      lx_mode = MODE_IDLE;
      bump_col();
      return;
    end
    code = op_single(op_byte);
    if (code >= 0) begin
      emit(KIND_OPERATOR, 4'(code), tok_line, tok_col, '0, '0, '0);
    end else if (op_byte == "=") begin
      emit(KIND_ASSIGN, 4'd0, tok_line, tok_col, '0, '0, '0);
    end else begin
      lex_fail(ERR_LONE_AMP_BAR, tok_line, tok_col);
      lex_halted(c);
      return;
    end
    lx_mode = MODE_IDLE;
    lex_fresh(c);
  endfunction

  function automatic void lex_byte(input logic [7:0] c);
    token_exp_t e;
    step_toks.delete();
    case (lx_mode)
      MODE_IDLE:     lex_fresh(c);
      MODE_NAME:     lex_in_name(c);
      MODE_NUMBER:   lex_in_number(c);
      MODE_OPERATOR: lex_in_operator(c);
      default:       lex_halted(c);
    endcase
    for (int i = 0; i < step_toks.size(); i++) begin
      e.tok = step_toks[i];
      e.last = (i == step_toks.size() - 1);
      token_q.push_back(e);
    end
  endfunction

  function automatic logic [63:0] pack_word(input string s);
    logic [63:0] w;
    w = '0;
    for (int i = 0; i < s.len() && i < 8; i++) w |= 64'(s[i]) << (8 * i);
    return w;
  endfunction

  function automatic logic [7:0] rand_alpha();
    string letters;
    letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    return letters[$urandom_range(0, letters.len() - 1)];
  endfunction

  function automatic void check_field(input string fname, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", fname, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && token_out.valid && token_out.ready) begin
      if (token_q.size() == 0) begin
        $error("token_kind: expected none, got %0d", token_out.token_kind);
        fail_count++;
      end else begin
        head_tok = token_q.pop_front();
        check_field("token_kind", head_tok.tok.token_kind, token_out.token_kind);
        check_field("detail", head_tok.tok.detail, token_out.detail);
        check_field("line", head_tok.tok.line, token_out.line);
        check_field("column", head_tok.tok.column, token_out.column);
        check_field("literal_value", head_tok.tok.literal_value, token_out.literal_value);
        check_field("name_char", head_tok.tok.name_char, token_out.name_char);
        check_field("name_position", head_tok.tok.name_position, token_out.name_position);
        check_field("last", head_tok.last, token_out.last);
        tokens_checked++;
      end
    end
  end

  // Token sink: random stall bursts, plus a long hold when one is requested.
  initial begin
    token_out.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_ticket != hold_served) begin
        hold_served = hold_ticket;
        token_out.ready <= 1'b0;
        repeat (250) @(posedge clk);
      end else if (sink_bursts && $urandom_range(0, 5) == 0) begin
        token_out.ready <= 1'b0;
        repeat ($urandom_range(0, 8)) @(posedge clk);
      end else begin
        token_out.ready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] c);
    if (send_gaps && $urandom_range(0, 4) == 0) begin
      char_in.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    char_in.valid <= 1'b1;
    char_in.char_code <= c;
    @(posedge clk);
    while (!char_in.ready) @(posedge clk);
    if (lx_mode != MODE_STOPPED) live_bytes++;
    lex_byte(c);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    send_byte(CH_NUL);
    streams++;
  endtask

  task automatic settle();
    char_in.valid <= 1'b0;
    while (token_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    if (idx == REG_KW_COUNT) kw_count = val[2:0];
    else kw_word[idx] = val;
    cfg_writes++;
  endtask

  task automatic set_keywords(input logic [63:0] a, input logic [63:0] b,
                              input logic [63:0] c, input logic [63:0] d,
                              input logic [63:0] n);
    settle();
    write_reg(REG_KW_A, a);
    write_reg(REG_KW_B, b);
    write_reg(REG_KW_C, c);
    write_reg(REG_KW_D, d);
    write_reg(REG_KW_COUNT, n);
    cfg.valid <= 1'b0;
  endtask

  task automatic test_symbols_and_operators();
    send_text("int {x}(y);\n -+/*!~<>&&||!=>= a==b=c<d>=e!f");
    send_text("x=");
  endtask

  task automatic test_keywords();
    kw_text = '{"int", "if", "abcdefgh", "while"};
    set_keywords(pack_word("int"), pack_word("if"), pack_word("abcdefgh"),
                 pack_word("while"), 64'd4);
    send_text("int if abcdefgh abcdefghi while in x");
    set_keywords(pack_word("int"), pack_word("if"), pack_word("abcdefgh"),
                 pack_word("while"), 64'd2);
    send_text("while if");
    set_keywords(pack_word("int"), pack_word("if"), pack_word("abcdefgh"),
                 pack_word("while"), 64'd7);
    send_text("while");
    set_keywords('1, '1, '0, '0, 64'd4);
    send_text("int");
    set_keywords(pack_word("int"), pack_word("int"), pack_word("for"),
                 pack_word("else"), 64'd0);
    kw_text = '{"int", "int", "for", "else"};
  endtask

  task automatic test_literals();
    send_text("0 007 9223372036854775807;12ab3_ 42\n");
    send_text("9223372036854775808+1");
  endtask

  task automatic test_errors();
    send_text("a & b");
    send_text("|");
    send_text("x\tabc;");
    send_byte(8'hFF);
    send_byte(8'h80);
    send_text("q");
  endtask

  task automatic test_overlong_names();
    for (int i = 0; i < 256; i++) send_byte(rand_alpha());
    send_text("");
  endtask

  task automatic test_backpressure();
    send_gaps = 1'b0;
    hold_ticket++;
    for (int i = 0; i < 10; i++) begin
      send_byte("a");
      send_byte(";");
    end
    send_text("");
    send_gaps = 1'b1;
  endtask

  task automatic random_keywords();
    logic [63:0] w [4];
    int n;
    for (int k = 0; k < 4; k++) begin
      if ($urandom_range(0, 3) == 0) begin
        w[k] = {$urandom, $urandom};
        kw_text[k] = "";
      end else begin
        n = $urandom_range(1, 8);
        kw_text[k] = "";
        for (int i = 0; i < n; i++) kw_text[k] = $sformatf("%s%c", kw_text[k], rand_alpha());
        w[k] = pack_word(kw_text[k]);
      end
    end
    set_keywords(w[0], w[1], w[2], w[3], 64'($urandom_range(0, 7)));
  endtask

  task automatic random_stream();
    int frags;
    int pick;
    int n;
    string s;
    frags = $urandom_range(3, 12);
    for (int f = 0; f < frags; f++) begin
      pick = $urandom_range(0, 39);
      if (pick < 10) begin
        s = kw_text[$urandom_range(0, 3)];
        if (pick < 4 && s.len() != 0) begin
          for (int i = 0; i < s.len(); i++) send_byte(s[i]);
        end else begin
          send_byte(rand_alpha());
          n = $urandom_range(0, 9);
          for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 3) == 0) send_byte(8'("0" + $urandom_range(0, 9)));
            else send_byte(rand_alpha());
          end
        end
      end else if (pick < 18) begin
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(18, 21) : $urandom_range(1, 4);
        for (int i = 0; i < n; i++) send_byte(8'("0" + $urandom_range(0, 9)));
        if ($urandom_range(0, 7) == 0) send_byte(rand_alpha());
      end else if (pick < 24) begin
        s = "{}();";
        send_byte(s[$urandom_range(0, 4)]);
      end else if (pick < 32) begin
        s = op_list[($urandom_range(0, 9) == 0) ? $urandom_range(0, 16) : $urandom_range(0, 14)];
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
      end else if (pick < 38) begin
        send_byte(($urandom_range(0, 2) == 0) ? CH_NL : CH_SPACE);
      end else begin
        send_byte(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 4) < 3) send_byte(CH_SPACE);
    end
    send_text("");
  endtask

  task automatic test_random_streams();
    int start;
    start = live_bytes;
    while (live_bytes - start < 40) begin
      if ($urandom_range(0, 3) == 0) random_keywords();
      if (live_bytes - start > 20) begin
        send_gaps = 1'b0;
        sink_bursts = 1'b0;
      end
      random_stream();
    end
  endtask

  initial begin
    rst = 1'b1;
    char_in.valid = 1'b0;
    char_in.char_code = CH_NUL;
    cfg.valid = 1'b0;
    cfg.index = REG_KW_A;
    cfg.data = '0;
    lex_restart();
    for (int k = 0; k < 4; k++) begin
      kw_word[k] = '0;
      kw_text[k] = "";
    end
    kw_count = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_symbols_and_operators();
    test_keywords();
    test_literals();
    test_errors();
    test_overlong_names();
    test_backpressure();
    test_random_streams();
    char_in.valid <= 1'b0;
    while (token_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Lexed %0d live bytes in %0d streams, checked %0d tokens, %0d register writes.",
             live_bytes, streams, tokens_checked, cfg_writes);
    $display("Included keywords, literal overflow, all operators, errors, an overlong name",
             " and a long output stall.");
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timed out with %0d tokens still outstanding.", token_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
